/* design/sorted_list_table_defines.svh */
// Assertion macros used by the checker file slt_checker.sv.
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

// Checked outside reset only.
`define SLT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every edge, reset included.
`define SLT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* design/slt_pkg.sv */
package slt_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int VAL_W      = 32;
   localparam int POS_W      = 5;
   localparam int ECNT_W     = 5;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [DATA_WIDTH-1:0] slt_data_type;
   typedef logic [VAL_W-1:0]      slt_word_type;
   typedef logic [POS_W-1:0]      slt_pos_type;
   typedef logic [ECNT_W-1:0]     slt_ecnt_type;
   typedef logic [CNT_W-1:0]      slt_cnt_type;
   typedef logic [IDX_W-1:0]      slt_idx_type;
   typedef logic [CMP_W-1:0]      slt_cmp_type;
   typedef logic [DEPTH-1:0]      slt_mask_type;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_DEL_POS = 2'd1,
      OP_DEL_KEY = 2'd2,
      OP_READ    = 2'd3
   } slt_op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_BADPOS = 2'd1,
      STAT_NOKEY  = 2'd2,
      STAT_FULL   = 2'd3
   } slt_status_type;

   typedef enum logic {
      S_IDLE  = 1'b0,
      S_APPLY = 1'b1
   } slt_state_type;

   typedef struct packed {
      logic capture;   // latch request and its compare vectors
      logic commit;    // update the list and load the result register
   } slt_cmd_type;

endpackage

/* design/slt_channels.sv */
interface slt_req_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic signed [31:0]      value;
   logic [4:0]              position;

   modport source (output valid, req_type, value, position, input ready);
   modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface slt_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [31:0]      read_value;
   logic [4:0]              entry_count;

   modport source (output valid, status, read_value, entry_count, input ready);
   modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

/* design/sorted_list_table.sv */
// channel   dir   handshake        word
// req_port  in    valid / ready    req_type, value, position
// rsp_port  out   valid / ready    status, read_value, entry_count
//
// Each word passes an accept step and an apply step: accept registers the per-lane compare vectors,
// apply shifts the entry register array and loads the result register.
// A new request is taken while a result word still waits on rsp_port.
// Apply holds while the result register is full and not being taken.
// Reset empties the list at once; entry contents stay undefined until written.
module sorted_list_table (
   input  logic       clock,
   input  logic       reset,
   slt_req_if.sink    req_port,
   slt_rsp_if.source  rsp_port
);

   slt_pkg::slt_cmd_type cmd;

   slt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_ready (rsp_port.ready),
      .rsp_valid (rsp_port.valid),
      .cmd       (cmd)
   );

   slt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_type    (req_port.req_type),
      .value       (req_port.value),
      .position    (req_port.position),
      .status      (rsp_port.status),
      .read_value  (rsp_port.read_value),
      .entry_count (rsp_port.entry_count)
   );

endmodule

/* design/slt_ctrl.sv */
module slt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output slt_pkg::slt_cmd_type cmd
);

   slt_pkg::slt_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         slt_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = slt_pkg::S_APPLY;
            end
         end
         slt_pkg::S_APPLY: begin
            // result register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = slt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = slt_pkg::S_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/slt_datapath.sv */
module slt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  slt_pkg::slt_cmd_type cmd,
   input  logic [1:0]           req_type,
   input  logic signed [31:0]   value,
   input  logic [4:0]           position,
   output logic [1:0]           status,
   output logic signed [31:0]   read_value,
   output logic [4:0]           entry_count
);

   slt_pkg::slt_data_type entries_ff [slt_pkg::DEPTH];
   slt_pkg::slt_data_type entries_in [slt_pkg::DEPTH];
   slt_pkg::slt_cnt_type  count_ff, count_in;

   slt_pkg::slt_op_type   op_ff, op_in;
   slt_pkg::slt_data_type val_ff, val_in;
   slt_pkg::slt_mask_type lt_ff, lt_in;
   slt_pkg::slt_mask_type del_ff, del_in;
   slt_pkg::slt_idx_type  idx_ff, idx_in;
   logic                  ok_ff, ok_in;

   slt_pkg::slt_status_type status_ff, status_in;
   slt_pkg::slt_word_type   rd_ff, rd_in;
   slt_pkg::slt_ecnt_type   ecnt_ff, ecnt_in;

   // capture: per-lane compares against the live list
   always_comb begin
      slt_pkg::slt_mask_type eq_v;
      slt_pkg::slt_mask_type one_v;
      slt_pkg::slt_mask_type thermo_v;
      slt_pkg::slt_pos_type  pos_v;
      logic                  pos_ok_v;
      logic                  used_v;

      val_in = slt_pkg::slt_data_type'(value);
      op_in  = slt_pkg::slt_op_type'(req_type);
      one_v  = '0;
      one_v[0] = 1'b1;
      pos_v  = (position == '0) ? slt_pkg::slt_pos_type'(1) : position;
      pos_ok_v = slt_pkg::slt_cmp_type'(pos_v) <= slt_pkg::slt_cmp_type'(count_ff);
      idx_in = slt_pkg::slt_idx_type'(pos_v - slt_pkg::slt_pos_type'(1));
      for (int i = 0; i < slt_pkg::DEPTH; i++) begin
         used_v      = slt_pkg::slt_cnt_type'(i) < count_ff;
         lt_in[i]    = used_v && ($signed(entries_ff[i]) < $signed(val_in));
         eq_v[i]     = used_v && (entries_ff[i] == val_in);
         thermo_v[i] = slt_pkg::slt_idx_type'(i) >= idx_in;
      end
      unique case (op_in)
         slt_pkg::OP_INSERT: begin
            ok_in  = count_ff < slt_pkg::slt_cnt_type'(slt_pkg::DEPTH);
            del_in = thermo_v;
         end
         slt_pkg::OP_DEL_KEY: begin
            ok_in  = |eq_v;
            // lanes at and above the first match
            del_in = eq_v | (~eq_v + one_v);
         end
         default: begin
            ok_in  = pos_ok_v;
            del_in = thermo_v;
         end
      endcase
   end

   // apply: shift the register array on insert and delete, and form the result word
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      if (ok_ff) begin
         unique case (op_ff)
            slt_pkg::OP_INSERT: begin
               if (!lt_ff[0]) begin
                  entries_in[0] = val_ff;
               end
               for (int i = 1; i < slt_pkg::DEPTH; i++) begin
                  if (lt_ff[i]) begin
                     entries_in[i] = entries_ff[i];
                  end else if (lt_ff[i-1]) begin
                     entries_in[i] = val_ff;
                  end else begin
                     entries_in[i] = entries_ff[i-1];
                  end
               end
               count_in = count_ff + slt_pkg::slt_cnt_type'(1);
            end
            slt_pkg::OP_DEL_POS, slt_pkg::OP_DEL_KEY: begin
               for (int i = 0; i < slt_pkg::DEPTH - 1; i++) begin
                  if (del_ff[i]) begin
                     entries_in[i] = entries_ff[i+1];
                  end
               end
               count_in = count_ff - slt_pkg::slt_cnt_type'(1);
            end
            default: begin
            end
         endcase
      end
      if (ok_ff) begin
         status_in = slt_pkg::STAT_OK;
      end else begin
         unique case (op_ff)
            slt_pkg::OP_INSERT:  status_in = slt_pkg::STAT_FULL;
            slt_pkg::OP_DEL_KEY: status_in = slt_pkg::STAT_NOKEY;
            default:             status_in = slt_pkg::STAT_BADPOS;
         endcase
      end
      if (ok_ff && (op_ff == slt_pkg::OP_READ)) begin
         rd_in = slt_pkg::slt_word_type'($signed(entries_ff[idx_ff]));
      end else begin
         rd_in = '0;
      end
      ecnt_in = slt_pkg::slt_ecnt_type'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         entries_ff <= entries_in;
         status_ff  <= status_in;
         rd_ff      <= rd_in;
         ecnt_ff    <= ecnt_in;
      end
      if (cmd.capture) begin
         op_ff  <= op_in;
         val_ff <= val_in;
         lt_ff  <= lt_in;
         del_ff <= del_in;
         idx_ff <= idx_in;
         ok_ff  <= ok_in;
      end
   end

   assign status      = status_ff;
   assign read_value  = rd_ff;
   assign entry_count = ecnt_ff;

endmodule

/* design/slt_checker.sv */
`include "sorted_list_table_defines.svh"

module slt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_read_value,
   input logic [4:0]         rsp_entry_count
);

   `SLT_ASSERT(a_one_at_a_time, (req_valid && req_ready) |=> !req_ready, "request taken during apply")
   `SLT_ASSERT(a_full_count, (rsp_valid && (rsp_status == slt_pkg::STAT_FULL)) |-> (rsp_entry_count == 5'(slt_pkg::DEPTH)), "full status with list not full")
   `SLT_ASSERT(a_read_zero, (rsp_valid && (rsp_status != slt_pkg::STAT_OK)) |-> (rsp_read_value == 32'sd0), "failed request returned data")
   `SLT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) && $stable(rsp_entry_count)), "stalled result word changed")
   `SLT_ASSERT_ALWAYS(a_reset_idle, reset |=> (!rsp_valid && req_ready), "not idle after reset")

endmodule

bind sorted_list_table slt_checker u_slt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_status      (rsp_port.status),
   .rsp_read_value  (rsp_port.read_value),
   .rsp_entry_count (rsp_port.entry_count)
);
